// ===== hw/rtl/swhc_pkg.sv =====
`timescale 1ns / 1ps

package swhc_pkg;

   localparam int TS_W  = 32;
   localparam int CNT_W = 16;
   localparam int SUM_W = 24;

   localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [SUM_W-1:0] SUM_MAX   = 24'hFFFFFF;

   // Request kinds carried in the req_type field.
   localparam logic REQ_HIT   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [TS_W-1:0]  stamp;
      logic [CNT_W-1:0] count;
   } bucket_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } acc_ctl_type;

endpackage

// ===== hw/rtl/swhc_req_if.sv =====
`timescale 1ns / 1ps

interface swhc_req_if;
   import swhc_pkg::*;

   logic            valid;
   logic            ready;
   logic            req_type;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, output req_type, output timestamp, input ready);
   modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

// ===== hw/rtl/swhc_rsp_if.sv =====
`timescale 1ns / 1ps

interface swhc_rsp_if;
   import swhc_pkg::*;

   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] window_count;

   modport source (output valid, output window_count, input ready);
   modport sink   (input valid, input window_count, output ready);
endinterface

// ===== hw/rtl/swhc_mod.sv =====
`timescale 1ns / 1ps

module swhc_mod #(
   parameter int WINDOW = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [swhc_pkg::TS_W-1:0]   dividend,
   output logic [$clog2(WINDOW)-1:0]   rem,
   output logic                        done
);
   import swhc_pkg::*;

   localparam int RW = $clog2(WINDOW);
   localparam logic [RW:0] DIV = (RW + 1)'(WINDOW);
   // Rounded-down reciprocal, so the quotient estimate is short by at most one.
   localparam logic [TS_W-1:0] RECIP = TS_W'((64'd1 << TS_W) / WINDOW);

   logic [2*TS_W-1:0] product;
   logic [TS_W-1:0]   quot_ff;
   logic [RW:0]       low_ff;
   logic              mul_vld_ff;
   logic [RW:0]       qw_low;
   logic [RW:0]       est_ff;
   logic              est_vld_ff;

   assign product = (2*TS_W)'(dividend) * (2*TS_W)'(RECIP);

   // The estimate stays below 2 * WINDOW, so only its low RW + 1 bits matter.
   assign qw_low = quot_ff[RW:0] * DIV;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         est_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= start;
         est_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= product[2*TS_W-1:TS_W];
         low_ff  <= dividend[RW:0];
      end
      if (mul_vld_ff) begin
         est_ff <= low_ff - qw_low;
      end
   end

   assign rem  = (est_ff >= DIV) ? RW'(est_ff - DIV) : est_ff[RW-1:0];
   assign done = est_vld_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      est_vld_ff |-> (rem < WINDOW))
      else $error("remainder out of range");

   a_est_range: assert property (@(posedge clock) disable iff (reset)
      est_vld_ff |-> ({1'b0, est_ff} < {DIV, 1'b0}))
      else $error("quotient estimate off by more than one");

   a_start_stage: assert property (@(posedge clock) disable iff (reset)
      start |=> mul_vld_ff)
      else $error("multiply stage not started");

   a_stage_chain: assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff |=> est_vld_ff)
      else $error("correction stage skipped");

endmodule

// ===== hw/rtl/swhc_accum.sv =====
`timescale 1ns / 1ps

module swhc_accum #(
   parameter int WINDOW = 256
) (
   input  logic                        clock,
   input  swhc_pkg::acc_ctl_type       ctl,
   input  logic [swhc_pkg::TS_W-1:0]   now,
   input  swhc_pkg::bucket_type        entry,
   output logic [swhc_pkg::SUM_W-1:0]  sum
);
   import swhc_pkg::*;

   logic [SUM_W-1:0] sum_ff;
   logic [TS_W-1:0]  age;
   logic             in_window;
   logic [SUM_W:0]   total;

   // Age wraps modulo 2^32, so a bucket stamped after the query never counts.
   assign age       = now - entry.stamp;
   assign in_window = (age < TS_W'(WINDOW));
   assign total     = {1'b0, sum_ff} + (SUM_W + 1)'(entry.count);

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         sum_ff <= '0;
      end else if (ctl.enable && in_window) begin
         if (total > {1'b0, SUM_MAX}) begin
            sum_ff <= SUM_MAX;
         end else begin
            sum_ff <= total[SUM_W-1:0];
         end
      end
   end

   assign sum = sum_ff;

endmodule

// ===== hw/rtl/sliding_window_hit_counter.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Payload                   Transfer
// req_chan  in    req_type, timestamp[31:0]  valid && ready
// rsp_chan  out   window_count[23:0]         valid && ready
//
// A hit goes from its transfer through the timestamp mod WINDOW unit, then a bucket
// read and write-back, before ready returns. Hits give no response.
// A query scan reads one bucket per cycle, then passes through ST_SCAN_END and ST_DONE.
// After reset a clearing pass zeroes every bucket of the memory; ready stays low.
// A query result waits in the output register while the next request is taken;
// ready is low outside idle, and the output holds the input off only when a finished query's result cannot be loaded.
module sliding_window_hit_counter #(
   parameter int WINDOW = 256
) (
   input  logic              clock,
   input  logic              reset,
   swhc_req_if.sink          req_chan,
   swhc_rsp_if.source        rsp_chan
);
   import swhc_pkg::*;

   localparam int AW = $clog2(WINDOW);
   localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_MOD      = 8'b0000_0100,
      ST_HIT_RD   = 8'b0000_1000,
      ST_HIT_WR   = 8'b0001_0000,
      ST_SCAN     = 8'b0010_0000,
      ST_SCAN_END = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic [TS_W-1:0]  now_ff, now_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] count_out_ff, count_out_in;
   logic             scan_vld_ff;

   bucket_type       mem [WINDOW];
   bucket_type       rd_data_ff;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   bucket_type       wr_data;

   logic             req_accept;
   logic             mod_start, mod_done;
   logic [AW-1:0]    mod_rem;
   acc_ctl_type      acc_ctl;
   logic [SUM_W-1:0] acc_sum;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   swhc_mod #(.WINDOW(WINDOW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_chan.timestamp),
      .rem      (mod_rem),
      .done     (mod_done)
   );

   swhc_accum #(.WINDOW(WINDOW)) u_accum (
      .clock (clock),
      .ctl   (acc_ctl),
      .now   (now_ff),
      .entry (rd_data_ff),
      .sum   (acc_sum)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      now_in       = now_ff;
      count_out_in = count_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;
      mod_start    = 1'b0;
      acc_ctl      = '{clear: 1'b0, enable: scan_vld_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               now_in = req_chan.timestamp;
               if (req_chan.req_type == REQ_HIT) begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end else begin
                  acc_ctl.clear = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               slot_in  = mod_rem;
               state_in = ST_HIT_RD;
            end
         end
         ST_HIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_ff;
            state_in = ST_HIT_WR;
         end
         ST_HIT_WR: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff;
            wr_data = rd_data_ff;
            if (rd_data_ff.stamp != now_ff) begin
               wr_data.stamp = now_ff;
               wr_data.count = CNT_W'(1);
            end else if (rd_data_ff.count != COUNT_MAX) begin
               wr_data.count = rd_data_ff.count + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            // The last bucket read is added in this cycle.
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               count_out_in = acc_sum;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         scan_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_vld_ff  <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      now_ff       <= now_in;
      count_out_ff <= count_out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.window_count = count_out_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside query completion");

   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && $past(state_ff) == ST_SCAN)
         |-> (idx_ff == $past(idx_ff) + AW'(1)))
      else $error("scan index skipped a bucket");

   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("remainder finished outside hit sequence");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == ST_DONE))
      else $error("query result dropped while output busy");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import swhc_pkg::*;

   localparam int WINDOW         = 256;
   localparam int HOLD_CYCLES    = 3 * WINDOW;
   localparam int WATCHDOG_LIMIT = 8 * WINDOW + 1000;
   localparam int RANDOM_ITEMS   = 900;

   logic clock;
   logic reset;

   swhc_req_if req_if ();
   swhc_rsp_if rsp_if ();

   sliding_window_hit_counter #(
      .WINDOW(WINDOW)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // Our own copy of the bucket ring, updated in transfer order.
   bucket_type ring [WINDOW];

   logic [SUM_W-1:0] expected_counts [$];
   int unsigned      failures;
   int unsigned      req_idle_max;
   int unsigned      rsp_idle_max;
   int unsigned      rsp_hold_cycles;
   int unsigned      rsp_wait;
   int unsigned      quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void record_hit(input logic [TS_W-1:0] stamp);
      int unsigned slot;
      slot = stamp % WINDOW;
      if (ring[slot].stamp != stamp) begin
         ring[slot].stamp = stamp;
         ring[slot].count = CNT_W'(1);
      end else if (ring[slot].count != COUNT_MAX) begin
         ring[slot].count = ring[slot].count + CNT_W'(1);
      end
   endfunction

   function automatic logic [SUM_W-1:0] window_sum(input logic [TS_W-1:0] stamp);
      logic [TS_W-1:0] age;
      logic [31:0]     total;
      total = 0;
      for (int i = 0; i < WINDOW; i++) begin
         // The age wraps modulo 2^32, so a bucket stamped after the query looks ancient.
         age = stamp - ring[i].stamp;
         if (age < WINDOW) begin
            total = total + 32'(ring[i].count);
            if (total > 32'(SUM_MAX)) begin
               total = 32'(SUM_MAX);
            end
         end
      end
      return total[SUM_W-1:0];
   endfunction

   task automatic send_req(input logic kind, input logic [TS_W-1:0] stamp);
      int unsigned gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= kind;
      req_if.timestamp <= stamp;
      do @(posedge clock); while (!req_if.ready);
      if (kind == REQ_HIT) begin
         record_hit(stamp);
      end else begin
         expected_counts.push_back(window_sum(stamp));
      end
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
   endtask

   // Result side: check every transfer and drop ready at random moments.
   always @(posedge clock) begin : rsp_side
      logic [SUM_W-1:0] want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_counts.size() == 0) begin
               $error("window_count: unexpected transfer, actual %0d", rsp_if.window_count);
               failures++;
            end else begin
               want = expected_counts.pop_front();
               if (rsp_if.window_count !== want) begin
                  $error("window_count: expected %0d, actual %0d", want,
                         rsp_if.window_count);
                  failures++;
               end
            end
            rsp_wait = $urandom_range(0, rsp_idle_max);
         end else if (!rsp_if.valid && rsp_idle_max > 0 && rsp_wait == 0 &&
                      $urandom_range(0, 31) == 0) begin
            rsp_wait = $urandom_range(1, rsp_idle_max);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Queries straight after reset see zeroed buckets; a hit at time zero
   // lands in a bucket that already carries that stamp.
   task automatic test_reset_state();
      send_req(REQ_QUERY, 32'd0);
      send_req(REQ_HIT, 32'd0);
      send_req(REQ_HIT, 32'd0);
      send_req(REQ_QUERY, 32'd0);
      send_req(REQ_QUERY, WINDOW - 1);
      send_req(REQ_QUERY, WINDOW);
   endtask

   task automatic test_window_edges();
      send_req(REQ_HIT, 32'd1000);
      send_req(REQ_HIT, 32'd1001);
      send_req(REQ_HIT, 32'd1000 + WINDOW - 1);
      send_req(REQ_QUERY, 32'd1000 + WINDOW - 1);
      send_req(REQ_QUERY, 32'd1000 + WINDOW);
   endtask

   task automatic test_decreasing_stamps();
      send_req(REQ_QUERY, 32'd999);
      send_req(REQ_HIT, 32'd500);
      send_req(REQ_QUERY, 32'd1000 + WINDOW);
      send_req(REQ_QUERY, 32'd600);
   endtask

   task automatic test_wraparound();
      send_req(REQ_HIT, 32'hFFFF_FFF0);
      send_req(REQ_HIT, 32'hFFFF_FFFF);
      send_req(REQ_HIT, 32'h0000_0000);
      send_req(REQ_HIT, 32'h0000_0005);
      send_req(REQ_QUERY, 32'h0000_0005);
      send_req(REQ_QUERY, 32'hFFFF_FFFF);
   endtask

   // The receiver stops long enough for the output register and the scan
   // to fill, so the request side must stall while the sender keeps offering.
   task automatic test_backpressure();
      logic [TS_W-1:0] stamp;
      wait_drain();
      stamp = $urandom;
      req_idle_max    = 0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 12; i++) begin
         send_req((i % 3 == 0) ? REQ_HIT : REQ_QUERY, stamp);
         stamp = stamp + $urandom_range(0, 2);
      end
      req_idle_max = 10;
      wait_drain();
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      logic [TS_W-1:0] stamp;
      int unsigned     pick;
      logic            kind;
      stamp = $urandom;
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 3) begin
            req_idle_max = 0;
            rsp_idle_max = 0;
         end else if (i == n_items / 2) begin
            req_idle_max = 10;
            rsp_idle_max = 10;
         end
         pick = $urandom_range(0, 99);
         // Mostly an orderly clock with many hits per second; now and then
         // a long step, a jump anywhere, or a step backward.
         if (pick < 3) begin
            stamp = $urandom;
         end else if (pick < 7) begin
            stamp = stamp - $urandom_range(1, WINDOW + 40);
         end else if (pick < 12) begin
            stamp = stamp + $urandom_range(WINDOW - 8, 2 * WINDOW);
         end else if (pick < 40) begin
            stamp = stamp + $urandom_range(1, 4);
         end
         kind = ($urandom_range(0, 99) < 35) ? REQ_QUERY : REQ_HIT;
         send_req(kind, stamp);
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.req_type  <= REQ_HIT;
      req_if.timestamp <= '0;
      failures        = 0;
      req_idle_max    = 10;
      rsp_idle_max    = 10;
      rsp_hold_cycles = 0;
      for (int i = 0; i < WINDOW; i++) begin
         ring[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_window_edges();
      test_decreasing_stamps();
      test_wraparound();
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      wait_drain();
      repeat (WINDOW + 40) @(posedge clock);
      if (failures == 0 && expected_counts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sliding_window_hit_counter.f =====
hw/rtl/swhc_pkg.sv
hw/rtl/swhc_req_if.sv
hw/rtl/swhc_rsp_if.sv
hw/rtl/swhc_mod.sv
hw/rtl/swhc_accum.sv
hw/rtl/sliding_window_hit_counter.sv
verif/tb.sv
